// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the view matrix checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Transaction types and fixed-point helpers for the look-at view matrix unit.
// ----------------------------------------------------------------------------
package lav_pkg;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
    logic signed [31:0] upvec_x;
    logic signed [31:0] upvec_y;
    logic signed [31:0] upvec_z;
  } lav_in_t;

  typedef struct packed {
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic signed [31:0] right_z;
    logic signed [31:0] camup_x;
    logic signed [31:0] camup_y;
    logic signed [31:0] camup_z;
    logic signed [31:0] forward_x;
    logic signed [31:0] forward_y;
    logic signed [31:0] forward_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } lav_out_t;

  typedef logic [2:0][31:0] lav_vec3_t;

  localparam int unsigned QFrac = 30;
  localparam logic signed [65:0] RoundHalf = 66'sd536870912;
  localparam logic signed [65:0] SatMax = 66'sd2147483647;
  localparam logic signed [65:0] SatMin = -66'sd2147483648;

  function automatic logic signed [63:0] smul(input logic [31:0] a, input logic [31:0] b);
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic signed [63:0] r;
    sa = a;
    sb = b;
    r = sa * sb;
    return r;
  endfunction

  function automatic logic [31:0] round_q30(input logic signed [63:0] x);
    logic signed [65:0] t;
    t = {{2{x[63]}}, x};
    t = t + RoundHalf;
    t = t >>> QFrac;
    return t[31:0];
  endfunction

  function automatic logic [31:0] trans_sat(input logic signed [63:0] dot);
    logic signed [65:0] e;
    logic signed [65:0] t;
    logic [31:0] r;
    e = {{2{dot[63]}}, dot};
    t = RoundHalf - e;
    t = t >>> QFrac;
    if (t > SatMax) begin
      r = 32'h7fff_ffff;
    end else if (t < SatMin) begin
      r = 32'h8000_0000;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/look_at_view_matrix_top.sv
// Throughput: one transaction per cycle unless the output is stalled;
// each normaliser is a 40-stage pipeline whose square root and dividers
// resolve two bits per stage.
// A stalled output freezes every stage; nothing is lost or repeated.
// Reset (asynchronous, active low) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// look_at_view_matrix_top
// Camera basis and translation from eye, aim and up vectors in fixed point.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lav_pkg::lav_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lav_pkg::lav_out_t out_data_o
);

  localparam int unsigned Side1W = 192;
  localparam int unsigned Side2W = 193;

  logic en;
  logic out_valid_q;
  lav_pkg::lav_out_t out_data_q;

  assign en         = ~(out_valid_q & out_stall_i);
  assign in_stall_o = ~en;

  lav_pkg::lav_vec3_t eye_in, aim_in, up_in;
  logic [2:0][33:0] d_d;

  assign eye_in = {in_data_i.eye_z, in_data_i.eye_y, in_data_i.eye_x};
  assign aim_in = {in_data_i.aim_z, in_data_i.aim_y, in_data_i.aim_x};
  assign up_in  = {in_data_i.upvec_z, in_data_i.upvec_y, in_data_i.upvec_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_d[i] = {{2{aim_in[i][31]}}, aim_in[i]};
      if (in_data_i.opcode) begin
        d_d[i] = d_d[i] - {{2{eye_in[i][31]}}, eye_in[i]};
      end
    end
  end

  logic               t1_v_q;
  logic [2:0][33:0]   t1_d_q;
  lav_pkg::lav_vec3_t t1_eye_q, t1_up_q;
  logic [2:0][63:0]   n1_vec;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n1_vec[i] = {{30{t1_d_q[i][33]}}, t1_d_q[i]};
    end
  end

  logic               n1_v, n1_nz;
  lav_pkg::lav_vec3_t n1_w, n1_eye, n1_up;

  lav_norm #(
    .SideW (Side1W)
  ) u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t1_v_q),
    .vec_i   (n1_vec),
    .side_i  ({t1_up_q, t1_eye_q}),
    .valid_o (n1_v),
    .nz_o    (n1_nz),
    .unit_o  (n1_w),
    .side_o  ({n1_up, n1_eye})
  );

  logic               t2_v_q, t2_nz_q;
  logic [2:0][63:0]   t2_pa_q, t2_pb_q;
  lav_pkg::lav_vec3_t t2_w_q, t2_eye_q;
  logic [2:0][63:0]   pa_d, pb_d;

  logic               t3_v_q, t3_nz_q;
  logic [2:0][63:0]   t3_c_q;
  lav_pkg::lav_vec3_t t3_w_q, t3_eye_q;

  logic               n2_v, n2_nz, n2_nz1;
  lav_pkg::lav_vec3_t n2_u, n2_w, n2_eye;

  lav_norm #(
    .SideW (Side2W)
  ) u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t3_v_q),
    .vec_i   (t3_c_q),
    .side_i  ({t3_nz_q, t3_w_q, t3_eye_q}),
    .valid_o (n2_v),
    .nz_o    (n2_nz),
    .unit_o  (n2_u),
    .side_o  ({n2_nz1, n2_w, n2_eye})
  );

  logic [2:0][63:0]   vpa_d, vpb_d, du_d, dw_d;
  logic               t4_v_q, t4_nz_q;
  logic [2:0][63:0]   t4_vpa_q, t4_vpb_q, t4_du_q, t4_dw_q;
  lav_pkg::lav_vec3_t t4_u_q, t4_w_q, t4_eye_q;

  logic               t5_v_q, t5_nz_q;
  lav_pkg::lav_vec3_t t5_u_q, t5_v3_q, t5_w_q, t5_eye_q;
  logic [63:0]        t5_dotu_q, t5_dotw_q;

  logic               t6_v_q, t6_nz_q;
  lav_pkg::lav_vec3_t t6_u_q, t6_v3_q, t6_w_q;
  logic [2:0][63:0]   t6_dv_q;
  logic [31:0]        t6_tu_q, t6_tw_q;

  logic               t7_v_q, t7_nz_q;
  lav_pkg::lav_vec3_t t7_u_q, t7_v3_q, t7_w_q;
  logic [63:0]        t7_dotv_q;
  logic [31:0]        t7_tu_q, t7_tw_q;

  for (genvar g = 0; g < 3; g++) begin : g_cross
    localparam int unsigned A = (g + 1) % 3;
    localparam int unsigned B = (g + 2) % 3;
    assign pa_d[g]  = lav_pkg::smul(n1_w[A], n1_up[B]);
    assign pb_d[g]  = lav_pkg::smul(n1_w[B], n1_up[A]);
    assign vpa_d[g] = lav_pkg::smul(n2_w[A], n2_u[B]);
    assign vpb_d[g] = lav_pkg::smul(n2_w[B], n2_u[A]);
    assign du_d[g]  = lav_pkg::smul(n2_u[g], n2_eye[g]);
    assign dw_d[g]  = lav_pkg::smul(n2_w[g], n2_eye[g]);
  end

  lav_pkg::lav_out_t out_d;

  always_comb begin
    out_d = '0;
    if (t7_nz_q) begin
      out_d.right_x   = t7_u_q[0];
      out_d.right_y   = t7_u_q[1];
      out_d.right_z   = t7_u_q[2];
      out_d.camup_x   = t7_v3_q[0];
      out_d.camup_y   = t7_v3_q[1];
      out_d.camup_z   = t7_v3_q[2];
      out_d.forward_x = t7_w_q[0];
      out_d.forward_y = t7_w_q[1];
      out_d.forward_z = t7_w_q[2];
      out_d.trans_x   = t7_tu_q;
      out_d.trans_y   = lav_pkg::trans_sat(t7_dotv_q);
      out_d.trans_z   = t7_tw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q      <= 1'b0;
      t2_v_q      <= 1'b0;
      t3_v_q      <= 1'b0;
      t4_v_q      <= 1'b0;
      t5_v_q      <= 1'b0;
      t6_v_q      <= 1'b0;
      t7_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      t1_v_q      <= in_valid_i;
      t2_v_q      <= n1_v;
      t3_v_q      <= t2_v_q;
      t4_v_q      <= n2_v;
      t5_v_q      <= t4_v_q;
      t6_v_q      <= t5_v_q;
      t7_v_q      <= t6_v_q;
      out_valid_q <= t7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_d_q   <= d_d;
      t1_eye_q <= eye_in;
      t1_up_q  <= up_in;

      t2_pa_q  <= pa_d;
      t2_pb_q  <= pb_d;
      t2_w_q   <= n1_w;
      t2_eye_q <= n1_eye;
      t2_nz_q  <= n1_nz;

      for (int i = 0; i < 3; i++) begin
        t3_c_q[i] <= t2_pa_q[i] - t2_pb_q[i];
      end
      t3_w_q   <= t2_w_q;
      t3_eye_q <= t2_eye_q;
      t3_nz_q  <= t2_nz_q;

      t4_vpa_q <= vpa_d;
      t4_vpb_q <= vpb_d;
      t4_du_q  <= du_d;
      t4_dw_q  <= dw_d;
      t4_u_q   <= n2_u;
      t4_w_q   <= n2_w;
      t4_eye_q <= n2_eye;
      t4_nz_q  <= n2_nz & n2_nz1;

      for (int i = 0; i < 3; i++) begin
        t5_v3_q[i] <= lav_pkg::round_q30(t4_vpa_q[i] - t4_vpb_q[i]);
      end
      t5_dotu_q <= t4_du_q[0] + t4_du_q[1] + t4_du_q[2];
      t5_dotw_q <= t4_dw_q[0] + t4_dw_q[1] + t4_dw_q[2];
      t5_u_q    <= t4_u_q;
      t5_w_q    <= t4_w_q;
      t5_eye_q  <= t4_eye_q;
      t5_nz_q   <= t4_nz_q;

      for (int i = 0; i < 3; i++) begin
        t6_dv_q[i] <= lav_pkg::smul(t5_v3_q[i], t5_eye_q[i]);
      end
      t6_tu_q  <= lav_pkg::trans_sat(t5_dotu_q);
      t6_tw_q  <= lav_pkg::trans_sat(t5_dotw_q);
      t6_u_q   <= t5_u_q;
      t6_v3_q  <= t5_v3_q;
      t6_w_q   <= t5_w_q;
      t6_nz_q  <= t5_nz_q;

      t7_dotv_q <= t6_dv_q[0] + t6_dv_q[1] + t6_dv_q[2];
      t7_tu_q   <= t6_tu_q;
      t7_tw_q   <= t6_tw_q;
      t7_u_q    <= t6_u_q;
      t7_v3_q   <= t6_v3_q;
      t7_w_q    <= t6_w_q;
      t7_nz_q   <= t6_nz_q;

      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: hdl/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined vector normaliser: block scaling, square root and three dividers.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int unsigned SideW = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2:0][63:0]      vec_i,
  input  logic [SideW-1:0]      side_i,
  output logic                  valid_o,
  output logic                  nz_o,
  output lav_pkg::lav_vec3_t    unit_o,
  output logic [SideW-1:0]      side_o
);

  localparam int unsigned SqPer    = 2;
  localparam int unsigned SqSteps  = 32 / SqPer;
  localparam int unsigned DivBits  = 31;
  localparam int unsigned DivPer   = 2;
  localparam int unsigned DivSteps = (DivBits + DivPer - 1) / DivPer;

  typedef struct packed {
    logic [2:0][30:0] m;
    logic [2:0]       sgn;
    logic             zero;
    logic [SideW-1:0] side;
  } carry_t;

  function automatic logic [3:0] hi16(input logic [15:0] x);
    logic [3:0] r;
    r = '0;
    for (int b = 0; b < 16; b++) begin
      if (x[b]) begin
        r = 4'(b);
      end
    end
    return r;
  endfunction

  logic             v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [2:0][63:0] mag1_q, mag2_q, mag3_q;
  logic [2:0]       sgn1_q, sgn2_q, sgn3_q;
  logic [SideW-1:0] side1_q, side2_q, side3_q;
  logic [3:0]       cnz2_q;
  logic [3:0][3:0]  cpos2_q;
  logic             rsh3_q, zero3_q;
  logic [5:0]       amt3_q;
  carry_t           c4_q, c5_q;
  logic [2:0][61:0] sq5_q;

  logic [63:0] or_w;
  logic [3:0]  cnz_d;
  logic [3:0][3:0] cpos_d;
  logic [5:0]  pos_d;
  logic [5:0]  amt_d;
  logic        rsh_d;
  carry_t      c4_d;

  always_comb begin
    or_w = mag1_q[0] | mag1_q[1] | mag1_q[2];
    for (int c = 0; c < 4; c++) begin
      cnz_d[c]  = |or_w[16*c +: 16];
      cpos_d[c] = hi16(or_w[16*c +: 16]);
    end
  end

  always_comb begin
    pos_d = '0;
    for (int c = 0; c < 4; c++) begin
      if (cnz2_q[c]) begin
        pos_d = {2'(c), cpos2_q[c]};
      end
    end
    rsh_d = (pos_d > 6'd30);
    amt_d = rsh_d ? (pos_d - 6'd30) : (6'd30 - pos_d);
  end

  always_comb begin
    c4_d.sgn  = sgn3_q;
    c4_d.zero = zero3_q;
    c4_d.side = side3_q;
    for (int i = 0; i < 3; i++) begin
      c4_d.m[i] = rsh3_q ? 31'(mag3_q[i] >> amt3_q) : 31'(mag3_q[i] << amt3_q);
    end
  end

  logic        sq_v_q    [SqSteps+1];
  logic [63:0] sq_rad_q  [SqSteps+1];
  logic [35:0] sq_rem_q  [SqSteps+1];
  logic [31:0] sq_root_q [SqSteps+1];
  carry_t      sq_c_q    [SqSteps+1];

  logic             dv_v_q   [DivSteps+1];
  logic [2:0][32:0] dv_rem_q [DivSteps+1];
  logic [2:0][30:0] dv_low_q [DivSteps+1];
  logic [2:0][30:0] dv_quo_q [DivSteps+1];
  logic [31:0]      dv_n_q   [DivSteps+1];
  carry_t           dv_c_q   [DivSteps+1];

  logic [2:0][61:0] num_d;
  logic             out_v_q;
  logic             out_nz_q;
  lav_pkg::lav_vec3_t out_unit_q;
  logic [SideW-1:0] out_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      v4_q       <= 1'b0;
      v5_q       <= 1'b0;
      sq_v_q[0]  <= 1'b0;
      dv_v_q[0]  <= 1'b0;
      out_v_q    <= 1'b0;
    end else if (en_i) begin
      v1_q       <= valid_i;
      v2_q       <= v1_q;
      v3_q       <= v2_q;
      v4_q       <= v3_q;
      v5_q       <= v4_q;
      sq_v_q[0]  <= v5_q;
      dv_v_q[0]  <= sq_v_q[SqSteps];
      out_v_q    <= dv_v_q[DivSteps];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = {sq_c_q[SqSteps].m[i], 31'b0} >> 1;
      num_d[i] = num_d[i] + 62'(sq_root_q[SqSteps] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sgn1_q[i] <= vec_i[i][63];
        mag1_q[i] <= vec_i[i][63] ? (~vec_i[i] + 64'd1) : vec_i[i];
      end
      side1_q <= side_i;

      cnz2_q  <= cnz_d;
      cpos2_q <= cpos_d;
      mag2_q  <= mag1_q;
      sgn2_q  <= sgn1_q;
      side2_q <= side1_q;

      rsh3_q  <= rsh_d;
      amt3_q  <= amt_d;
      zero3_q <= ~|cnz2_q;
      mag3_q  <= mag2_q;
      sgn3_q  <= sgn2_q;
      side3_q <= side2_q;

      c4_q <= c4_d;

      for (int i = 0; i < 3; i++) begin
        sq5_q[i] <= 62'(c4_q.m[i]) * 62'(c4_q.m[i]);
      end
      c5_q <= c4_q;

      sq_rad_q[0]  <= 64'(sq5_q[0]) + 64'(sq5_q[1]) + 64'(sq5_q[2]);
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_c_q[0]    <= c5_q;

      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= 33'(num_d[i][61:31]);
        dv_low_q[0][i] <= num_d[i][30:0];
        dv_quo_q[0][i] <= '0;
      end
      dv_n_q[0] <= sq_root_q[SqSteps];
      dv_c_q[0] <= sq_c_q[SqSteps];

      out_nz_q   <= ~dv_c_q[DivSteps].zero;
      out_side_q <= dv_c_q[DivSteps].side;
      for (int i = 0; i < 3; i++) begin
        if (dv_c_q[DivSteps].zero) begin
          out_unit_q[i] <= '0;
        end else if (dv_c_q[DivSteps].sgn[i]) begin
          out_unit_q[i] <= 32'd0 - {1'b0, dv_quo_q[DivSteps][i]};
        end else begin
          out_unit_q[i] <= {1'b0, dv_quo_q[DivSteps][i]};
        end
      end
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    logic [63:0] rad;
    logic [35:0] rem;
    logic [35:0] trial;
    logic [31:0] root;

    always_comb begin
      rad   = sq_rad_q[k];
      rem   = sq_rem_q[k];
      root  = sq_root_q[k];
      trial = '0;
      for (int j = 0; j < SqPer; j++) begin
        rem   = {rem[33:0], rad[63:62]};
        trial = {2'b00, root, 2'b01};
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[30:0], 1'b1};
        end else begin
          root = {root[30:0], 1'b0};
        end
        rad = {rad[61:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_rad_q[k+1]  <= rad;
        sq_rem_q[k+1]  <= rem;
        sq_root_q[k+1] <= root;
        sq_c_q[k+1]    <= sq_c_q[k];
      end
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [2:0][32:0] rem;
    logic [2:0][30:0] low;
    logic [2:0][30:0] quo;

    always_comb begin
      rem = dv_rem_q[k];
      low = dv_low_q[k];
      quo = dv_quo_q[k];
      for (int j = 0; j < DivPer; j++) begin
        if (k * DivPer + j < DivBits) begin
          for (int i = 0; i < 3; i++) begin
            rem[i] = {rem[i][31:0], low[i][30]};
            low[i] = {low[i][29:0], 1'b0};
            if (rem[i] >= {1'b0, dv_n_q[k]}) begin
              rem[i] = rem[i] - {1'b0, dv_n_q[k]};
              quo[i] = {quo[i][29:0], 1'b1};
            end else begin
              quo[i] = {quo[i][29:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_rem_q[k+1] <= rem;
        dv_low_q[k+1] <= low;
        dv_quo_q[k+1] <= quo;
        dv_n_q[k+1]   <= dv_n_q[k];
        dv_c_q[k+1]   <= dv_c_q[k];
      end
    end
  end

  assign valid_o = out_v_q;
  assign nz_o    = out_nz_q;
  assign unit_o  = out_unit_q;
  assign side_o  = out_side_q;

endmodule

// File: hdl/lav_checker.sv
// ----------------------------------------------------------------------------
// lav_checker
// Port-level checks on flow control and degenerate results of the view unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lav_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_i,
  input logic              out_valid_i,
  input logic              out_stall_i,
  input lav_pkg::lav_out_t out_data_i
);

  logic fwd_zero;
  logic right_zero;

  assign fwd_zero = (out_data_i.forward_x == 32'h0) && (out_data_i.forward_y == 32'h0) &&
                    (out_data_i.forward_z == 32'h0);
  assign right_zero = (out_data_i.right_x == 32'h0) && (out_data_i.right_y == 32'h0) &&
                      (out_data_i.right_z == 32'h0);

  `ASSERT_IMPLY(a_stall_only_on_held_result, clk_i, rst_ni, in_stall_i, out_valid_i && out_stall_i)
  `ASSERT_NEXT(a_held_result_stable, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i))
  `ASSERT_IMPLY(a_zero_fwd_zero_trans, clk_i, rst_ni, out_valid_i && fwd_zero, (out_data_i.trans_x == 32'h0) && (out_data_i.trans_y == 32'h0) && (out_data_i.trans_z == 32'h0))
  `ASSERT_IMPLY(a_zero_right_zero_up, clk_i, rst_ni, out_valid_i && right_zero, (out_data_i.camup_x == 32'h0) && (out_data_i.camup_y == 32'h0) && (out_data_i.camup_z == 32'h0))

endmodule

bind look_at_view_matrix_top lav_checker u_lav_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
